/* hw/rtl/spgs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spgs_pkg
// Shared widths, constants, types and helper functions of the spectral
// Poisson Green-function scaler.
// ----------------------------------------------------------------------------
package spgs_pkg;

  // Field widths.
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned IDX_DEPTH = 1 << IDX_W;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned SCALE_W   = 32;
  localparam int unsigned SQ_W      = 17;   // sin^2 in Q1.16, up to just over 1.0
  localparam int unsigned SUM_W     = 18;   // sum of three sin^2 terms
  localparam int unsigned PROD_W    = 64;   // |coef| * scale plus rounding
  localparam int unsigned Q_W       = 32;   // quotient bits kept
  localparam int unsigned REM_W     = SUM_W;

  // Divider organization: quotient bits resolved per pipeline stage.
  localparam int unsigned DIV_SPS    = 4;
  localparam int unsigned DIV_STAGES = Q_W / DIV_SPS;

  // Constants.
  localparam logic [63:0]        PI_Q30       = 64'd3373259426;
  localparam int unsigned        TAYLOR_TERMS = 8;
  localparam logic [SCALE_W-1:0] SCALE_RESET  = 32'h0001_0000;
  localparam logic [Q_W-1:0]     POS_MAX      = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0]     NEG_MIN      = 32'h8000_0000;

  // Status that rides along with every item.
  typedef struct packed {
    logic dc;
    logic neg_re;
    logic neg_im;
  } spgs_side_t;

  // Front end result: rounded dividends and the divisor.
  typedef struct packed {
    logic [PROD_W-1:0] num_re;
    logic [PROD_W-1:0] num_im;
    logic [SUM_W-1:0]  den;
    spgs_side_t        side;
  } spgs_num_t;

  // Divider result: quotients and overflow flags.
  typedef struct packed {
    logic [Q_W-1:0] q_re;
    logic [Q_W-1:0] q_im;
    logic           ovf_re;
    logic           ovf_im;
    spgs_side_t     side;
  } spgs_quot_t;

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                              input logic             nb,
                                              input logic [SUM_W-1:0] den);
    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    trial = {rem, nb};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return {1'b1, diff[REM_W-1:0]};
    end else begin
      return {1'b0, trial[REM_W-1:0]};
    end
  endfunction

  // Sign and saturation of one part: returns {saturated, value}.
  function automatic logic [Q_W:0] sat_part(input logic [Q_W-1:0] q,
                                            input logic           ovf,
                                            input logic           neg);
    logic [Q_W-1:0] negq;
    negq = (~q) + 1'b1;
    if (neg) begin
      // A negative coefficient gives a positive potential.
      if (ovf || (q > POS_MAX)) begin
        return {1'b1, POS_MAX};
      end else begin
        return {1'b0, q};
      end
    end else begin
      if (ovf || (q > NEG_MIN)) begin
        return {1'b1, NEG_MIN};
      end else begin
        return {1'b0, negq};
      end
    end
  endfunction

endpackage : spgs_pkg
`default_nettype wire

/* hw/rtl/spgs_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spgs_front
// Three-stage front end: sin^2 table lookup and coefficient magnitudes,
// then the sum S and the scale products, then the rounding offset S/2.
// ----------------------------------------------------------------------------
module spgs_front #(
  parameter int unsigned GRID_SIZE = 64
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire  [spgs_pkg::SCALE_W-1:0]         scale,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [spgs_pkg::IDX_W-1:0]           index_x,
  input  wire  [spgs_pkg::IDX_W-1:0]           index_y,
  input  wire  [spgs_pkg::IDX_W-1:0]           index_z,
  input  wire  signed [spgs_pkg::COEF_W-1:0]   coef_real,
  input  wire  signed [spgs_pkg::COEF_W-1:0]   coef_imag,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output spgs_pkg::spgs_num_t                  out_num
);
  import spgs_pkg::*;

  // Constant sin^2 table over every index value, folded at elaboration.
  logic [SQ_W-1:0] sq_tab [IDX_DEPTH];

  for (genvar gi = 0; gi < IDX_DEPTH; gi++) begin : g_tab
    localparam int unsigned IMOD = gi % GRID_SIZE;
    localparam int unsigned AMAG = (IMOD <= GRID_SIZE / 2) ? IMOD : GRID_SIZE - IMOD;
    localparam logic [63:0] T_Q30 = (PI_Q30 * 64'(AMAG)) / 64'(GRID_SIZE);
    // Taylor series of sin in Q2.30 up to t^17, each term built from the last.
    localparam logic [63:0] T2   = (T_Q30 * T_Q30) >> 30;
    localparam logic [63:0] TM3  = ((T_Q30 * T2) >> 30) / 64'd6;
    localparam logic [63:0] TM5  = ((TM3 * T2) >> 30) / 64'd20;
    localparam logic [63:0] TM7  = ((TM5 * T2) >> 30) / 64'd42;
    localparam logic [63:0] TM9  = ((TM7 * T2) >> 30) / 64'd72;
    localparam logic [63:0] TM11 = ((TM9 * T2) >> 30) / 64'd110;
    localparam logic [63:0] TM13 = ((TM11 * T2) >> 30) / 64'd156;
    localparam logic [63:0] TM15 = ((TM13 * T2) >> 30) / 64'd210;
    localparam logic [63:0] TM17 = ((TM15 * T2) >> 30) / 64'd272;
    localparam longint SIN_ACC = longint'(T_Q30) - longint'(TM3) + longint'(TM5)
                               - longint'(TM7) + longint'(TM9) - longint'(TM11)
                               + longint'(TM13) - longint'(TM15) + longint'(TM17);
    localparam logic [63:0] SIN_Q30 = (SIN_ACC < 0) ? 64'd0 : 64'(SIN_ACC);
    // Square in Q60, rounded half up to Q16.
    localparam logic [63:0] SQ_Q16 = (SIN_Q30 * SIN_Q30 + (64'd1 << 43)) >> 44;
    localparam logic [SQ_W-1:0] SQ_VAL = SQ_Q16[SQ_W-1:0];
    assign sq_tab[gi] = SQ_VAL;
  end

  // Stage handshake: a stage loads when it is empty or its successor loads.
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Stage 1: table reads and coefficient magnitudes.
  logic [SQ_W-1:0]   sqx_r, sqy_r, sqz_r;
  logic [COEF_W-1:0] mag_re_r, mag_im_r;
  logic              neg_re_r, neg_im_r;
  logic [COEF_W-1:0] raw_re, raw_im;

  assign raw_re = coef_real;
  assign raw_im = coef_imag;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      sqx_r    <= sq_tab[index_x];
      sqy_r    <= sq_tab[index_y];
      sqz_r    <= sq_tab[index_z];
      mag_re_r <= raw_re[COEF_W-1] ? ((~raw_re) + 1'b1) : raw_re;
      mag_im_r <= raw_im[COEF_W-1] ? ((~raw_im) + 1'b1) : raw_im;
      neg_re_r <= raw_re[COEF_W-1];
      neg_im_r <= raw_im[COEF_W-1];
    end
  end

  // Stage 2: the sum S and the two scale products.
  logic [SUM_W-1:0]  s2_r;
  logic [PROD_W-1:0] prod_re_r, prod_im_r;
  logic              neg_re2_r, neg_im2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_r      <= SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);
      prod_re_r <= PROD_W'(mag_re_r) * PROD_W'(scale);
      prod_im_r <= PROD_W'(mag_im_r) * PROD_W'(scale);
      neg_re2_r <= neg_re_r;
      neg_im2_r <= neg_im_r;
    end
  end

  // Stage 3: add half the divisor for round half up; flag the DC mode.
  spgs_num_t num_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      num_r.num_re      <= prod_re_r + PROD_W'(s2_r >> 1);
      num_r.num_im      <= prod_im_r + PROD_W'(s2_r >> 1);
      num_r.den         <= s2_r;
      num_r.side.dc     <= (s2_r == '0);
      num_r.side.neg_re <= neg_re2_r;
      num_r.side.neg_im <= neg_im2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_num   = num_r;

endmodule : spgs_front
`default_nettype wire

/* hw/rtl/spgs_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spgs_divider
// Pipelined restoring divider for the real and imaginary dividends by the
// shared divisor S. Each stage resolves DIV_SPS (four) quotient bits; the first stage
// also flags quotients that do not fit in 32 bits.
// ----------------------------------------------------------------------------
module spgs_divider (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  spgs_pkg::spgs_num_t   in_num,
  output logic                  out_valid,
  input  wire                   out_ready,
  output spgs_pkg::spgs_quot_t  out_quot
);
  import spgs_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0] rem_re;
    logic [REM_W-1:0] rem_im;
    logic [Q_W-1:0]   low_re;
    logic [Q_W-1:0]   low_im;
    logic [Q_W-1:0]   q_re;
    logic [Q_W-1:0]   q_im;
    logic [SUM_W-1:0] den;
    logic             ovf_re;
    logic             ovf_im;
    spgs_side_t       side;
  } div_st_t;

  logic [DIV_STAGES-1:0] v_r;
  logic [DIV_STAGES:0]   rdy;
  div_st_t               st_r   [DIV_STAGES];
  div_st_t               st_src [DIV_STAGES];
  div_st_t               st_nxt [DIV_STAGES];
  logic [Q_W-1:0]        hi_re, hi_im;

  // Ready chain: a stage loads when it is empty or its successor loads.
  always_comb begin
    rdy[DIV_STAGES] = out_ready;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  // Entry: the upper dividend half is the first partial remainder. A quotient
  // of 2^32 or more shows as an upper half not below the divisor.
  assign hi_re = in_num.num_re[PROD_W-1 -: Q_W];
  assign hi_im = in_num.num_im[PROD_W-1 -: Q_W];

  always_comb begin
    st_src[0].rem_re = hi_re[REM_W-1:0];
    st_src[0].rem_im = hi_im[REM_W-1:0];
    st_src[0].low_re = in_num.num_re[Q_W-1:0];
    st_src[0].low_im = in_num.num_im[Q_W-1:0];
    st_src[0].q_re   = '0;
    st_src[0].q_im   = '0;
    st_src[0].den    = in_num.den;
    st_src[0].ovf_re = (hi_re >= Q_W'(in_num.den));
    st_src[0].ovf_im = (hi_im >= Q_W'(in_num.den));
    st_src[0].side   = in_num.side;
    for (int k = 1; k < DIV_STAGES; k++) begin
      st_src[k] = st_r[k-1];
    end
  end

  // Each stage shifts in the next dividend bits and resolves quotient bits.
  always_comb begin
    div_st_t        st;
    logic [REM_W:0] rs_re;
    logic [REM_W:0] rs_im;
    for (int k = 0; k < DIV_STAGES; k++) begin
      st = st_src[k];
      for (int j = 0; j < DIV_SPS; j++) begin
        rs_re     = div_step(st.rem_re, st.low_re[Q_W-1], st.den);
        rs_im     = div_step(st.rem_im, st.low_im[Q_W-1], st.den);
        st.rem_re = rs_re[REM_W-1:0];
        st.rem_im = rs_im[REM_W-1:0];
        st.q_re   = {st.q_re[Q_W-2:0], rs_re[REM_W]};
        st.q_im   = {st.q_im[Q_W-2:0], rs_im[REM_W]};
        st.low_re = {st.low_re[Q_W-2:0], 1'b0};
        st.low_im = {st.low_im[Q_W-2:0], 1'b0};
      end
      st_nxt[k] = st;
    end
  end

  // Valid bits travel with the stage data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage data registers.
  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (rdy[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_valid       = v_r[DIV_STAGES-1];
  assign out_quot.q_re   = st_r[DIV_STAGES-1].q_re;
  assign out_quot.q_im   = st_r[DIV_STAGES-1].q_im;
  assign out_quot.ovf_re = st_r[DIV_STAGES-1].ovf_re;
  assign out_quot.ovf_im = st_r[DIV_STAGES-1].ovf_im;
  assign out_quot.side   = st_r[DIV_STAGES-1].side;

endmodule : spgs_divider
`default_nettype wire

/* hw/rtl/spectral_poisson_green_scaler.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one transfer per cycle while out_ready holds; a stage loads whenever it
// is empty or its successor loads. The pipeline holds three front-end stages, eight
// divider stages of four quotient bits each, and one output register.
// Reset (synchronous, rst_n low) empties the pipeline and sets the scale to 1.0.
// ----------------------------------------------------------------------------
// spectral_poisson_green_scaler
// Fourier-space Green-function scaling for a periodic 3D Poisson solve:
// potential = -scale * coef / S with S the sum of three sin^2 terms.
// ----------------------------------------------------------------------------
module spectral_poisson_green_scaler #(
  parameter int unsigned GRID_SIZE = 64
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // Configuration port.
  input  wire                                 cfg_we,
  input  wire  [spgs_pkg::SCALE_W-1:0]        cfg_wdata,
  // Input channel.
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [spgs_pkg::IDX_W-1:0]          in_index_x,
  input  wire  [spgs_pkg::IDX_W-1:0]          in_index_y,
  input  wire  [spgs_pkg::IDX_W-1:0]          in_index_z,
  input  wire  signed [spgs_pkg::COEF_W-1:0]  in_coef_real,
  input  wire  signed [spgs_pkg::COEF_W-1:0]  in_coef_imag,
  // Result channel.
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [spgs_pkg::Q_W-1:0]     out_pot_real,
  output logic signed [spgs_pkg::Q_W-1:0]     out_pot_imag,
  output logic                                out_dc_zeroed,
  output logic                                out_saturated
);
  import spgs_pkg::*;

  // Scale register, h^2/4 in Q16.16.
  logic [SCALE_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  // Front end.
  logic      fr_valid, fr_ready;
  spgs_num_t fr_num;

  spgs_front #(
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .scale     (scale_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .index_x   (in_index_x),
    .index_y   (in_index_y),
    .index_z   (in_index_z),
    .coef_real (in_coef_real),
    .coef_imag (in_coef_imag),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_num   (fr_num)
  );

  // Divider.
  logic       dv_valid, dv_ready;
  spgs_quot_t dv_quot;

  spgs_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_num    (fr_num),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_quot  (dv_quot)
  );

  // Output stage: sign, saturation and the DC override.
  logic           out_valid_r;
  logic [Q_W-1:0] pot_re_r, pot_im_r, pot_re_nxt, pot_im_nxt;
  logic           dc_r, sat_r, dc_nxt, sat_nxt;
  logic [Q_W:0]   part_re, part_im;

  assign dv_ready = !out_valid_r || out_ready;
  assign part_re  = sat_part(dv_quot.q_re, dv_quot.ovf_re, dv_quot.side.neg_re);
  assign part_im  = sat_part(dv_quot.q_im, dv_quot.ovf_im, dv_quot.side.neg_im);

  always_comb begin
    if (dv_quot.side.dc) begin
      pot_re_nxt = '0;
      pot_im_nxt = '0;
      dc_nxt     = 1'b1;
      sat_nxt    = 1'b0;
    end else begin
      pot_re_nxt = part_re[Q_W-1:0];
      pot_im_nxt = part_im[Q_W-1:0];
      dc_nxt     = 1'b0;
      sat_nxt    = part_re[Q_W] || part_im[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dv_ready) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ready) begin
      pot_re_r <= pot_re_nxt;
      pot_im_r <= pot_im_nxt;
      dc_r     <= dc_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pot_real  = pot_re_r;
  assign out_pot_imag  = pot_im_r;
  assign out_dc_zeroed = dc_r;
  assign out_saturated = sat_r;

  // A DC result is exactly zero and never counts as clipped.
  a_dc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dc_zeroed |-> (pot_re_r == '0) && (pot_im_r == '0) && !out_saturated)
    else $error("DC result is not zero");

  // A clipped result holds a range limit in at least one part.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (pot_re_r == POS_MAX) || (pot_re_r == NEG_MIN) ||
      (pot_im_r == POS_MAX) || (pot_im_r == NEG_MIN))
    else $error("saturated flag without a clipped part");

  // Input back-pressure only arises from a full pipeline behind a stalled output.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the output is free");

endmodule : spectral_poisson_green_scaler
`default_nettype wire

/* tb/spectral_poisson_green_scaler_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_poisson_green_scaler_tb
// Self-checking bench for the spectral Green-function scaler. A short table of
// probe modes (DC, Nyquist, clipping edges, zero and full-scale spacing) runs
// first, followed by random modes under several spacing settings. Each result is
// checked field by field against a hand-derived value (pinned probes) or a bench
// fixed-point model of the inverse Laplacian, with random stalls on both channels.
// ----------------------------------------------------------------------------
module spectral_poisson_green_scaler_tb;
  import spgs_pkg::*;

  localparam int unsigned GRID         = 64;
  localparam int unsigned HALF_GRID    = GRID / 2;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned IDLE_PCT     = 29;
  localparam int unsigned RAND_PHASES  = 5;
  localparam int unsigned PHASE_ITEMS  = 190;
  localparam int unsigned PROBE_COUNT  = 22;

  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_RESET;
  localparam logic [SCALE_W-1:0] SCALE_TWO = 32'h0002_0000;
  localparam logic [SCALE_W-1:0] SCALE_MAX = 32'hFFFF_FFFF;
  localparam logic [SCALE_W-1:0] SCALE_MIN = 32'h0000_0000;
  localparam logic [SCALE_W-1:0] SCALE_LSB = 32'h0000_0001;

  typedef struct packed {
    logic [Q_W-1:0] pot_real;
    logic [Q_W-1:0] pot_imag;
    logic           dc_zeroed;
    logic           saturated;
  } potential_t;

  typedef struct packed {
    logic [IDX_W-1:0]  ix;
    logic [IDX_W-1:0]  iy;
    logic [IDX_W-1:0]  iz;
    logic [COEF_W-1:0] re;
    logic [COEF_W-1:0] im;
  } mode_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    mode_t              mode;
    logic               pinned;
    potential_t         want;
  } probe_t;

  localparam potential_t ALL_ZERO     = '0;
  localparam potential_t DC_ZERO      = '{'0, '0, 1'b1, 1'b0};
  localparam potential_t BOTH_CLIPPED = '{NEG_MIN, POS_MAX, 1'b0, 1'b1};

  // Probe modes. Rows with pinned set carry a hand-derived result; the others
  // are checked against the bench model.
  probe_t probe_rows [PROBE_COUNT] = '{
    '{SCALE_ONE, '{6'd0,  6'd0,  6'd0,  32'h1234_5678, 32'hFFFF_FFFB}, 1'b1, DC_ZERO},
    '{SCALE_ONE, '{6'd0,  6'd0,  6'd0,  32'h7FFF_FFFF, 32'h8000_0000}, 1'b1, DC_ZERO},
    '{SCALE_ONE, '{6'd32, 6'd32, 6'd32, 32'h0001_0000, 32'hFFFF_0000}, 1'b0, ALL_ZERO},
    '{SCALE_ONE, '{6'd1,  6'd0,  6'd0,  32'h7FFF_FFFF, 32'h8000_0000}, 1'b1, BOTH_CLIPPED},
    '{SCALE_ONE, '{6'd63, 6'd63, 6'd63, 32'h0000_0000, 32'h0000_0000}, 1'b1, ALL_ZERO},
    '{SCALE_ONE, '{6'd33, 6'd31, 6'd63, 32'h0003_8000, 32'hFFFC_1234}, 1'b0, ALL_ZERO},
    '{SCALE_ONE, '{6'd16, 6'd48, 6'd0,  32'h0001_0000, 32'h0001_0000}, 1'b0, ALL_ZERO},
    '{SCALE_ONE, '{6'd32, 6'd32, 6'd32, 32'h0000_0001, 32'hFFFF_FFFF}, 1'b0, ALL_ZERO},
    '{SCALE_ONE, '{6'd0,  6'd0,  6'd1,  32'hFFFF_FFFF, 32'h0000_0001}, 1'b0, ALL_ZERO},
    '{SCALE_ONE, '{6'd0,  6'd32, 6'd0,  32'h4000_0000, 32'hC000_0000}, 1'b0, ALL_ZERO},
    '{SCALE_ONE, '{6'd0,  6'd32, 6'd0,  32'h8000_0000, 32'h8000_0001}, 1'b0, ALL_ZERO},
    '{SCALE_ONE, '{6'd0,  6'd1,  6'd0,  32'h0000_1000, 32'hFFFF_F000}, 1'b0, ALL_ZERO},
    '{SCALE_TWO, '{6'd0,  6'd32, 6'd0,  32'h4000_0000, 32'h3FFF_FFFF}, 1'b0, ALL_ZERO},
    '{SCALE_TWO, '{6'd0,  6'd32, 6'd0,  32'h4000_0001, 32'hC000_0000}, 1'b0, ALL_ZERO},
    '{SCALE_MIN, '{6'd5,  6'd7,  6'd9,  32'h7FFF_FFFF, 32'h8000_0000}, 1'b1, ALL_ZERO},
    '{SCALE_MIN, '{6'd0,  6'd0,  6'd0,  32'h0000_0001, 32'h0000_0001}, 1'b1, DC_ZERO},
    '{SCALE_MAX, '{6'd1,  6'd0,  6'd0,  32'h7FFF_FFFF, 32'h8000_0000}, 1'b1, BOTH_CLIPPED},
    '{SCALE_MAX, '{6'd32, 6'd32, 6'd32, 32'h0001_0000, 32'hFFFF_0000}, 1'b0, ALL_ZERO},
    '{SCALE_MAX, '{6'd32, 6'd32, 6'd32, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b1, BOTH_CLIPPED},
    '{SCALE_MAX, '{6'd0,  6'd0,  6'd0,  32'h7FFF_FFFF, 32'h8000_0000}, 1'b1, DC_ZERO},
    '{SCALE_LSB, '{6'd32, 6'd0,  6'd0,  32'h7FFF_FFFF, 32'h8000_0000}, 1'b0, ALL_ZERO},
    '{SCALE_LSB, '{6'd1,  6'd1,  6'd1,  32'h0000_0001, 32'hFFFF_FFFF}, 1'b0, ALL_ZERO}
  };

  // Block inputs, all known from time zero.
  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               cfg_we       = 1'b0;
  logic [SCALE_W-1:0] cfg_wdata    = '0;
  logic               in_valid     = 1'b0;
  logic [IDX_W-1:0]   in_index_x   = '0;
  logic [IDX_W-1:0]   in_index_y   = '0;
  logic [IDX_W-1:0]   in_index_z   = '0;
  logic [COEF_W-1:0]  in_coef_real = '0;
  logic [COEF_W-1:0]  in_coef_imag = '0;
  logic               out_ready    = 1'b0;

  // Block outputs.
  logic                  in_ready;
  logic                  out_valid;
  logic signed [Q_W-1:0] out_pot_real;
  logic signed [Q_W-1:0] out_pot_imag;
  logic                  out_dc_zeroed;
  logic                  out_saturated;

  // Hand-derived result that travels with the current input item.
  logic       pin_on   = 1'b0;
  potential_t pin_want = '0;

  // Bench model state and bookkeeping.
  logic [SCALE_W-1:0] green_scale = SCALE_RESET;
  longint unsigned    sin_sq_lut [HALF_GRID+1];
  potential_t         pending_potentials [$];
  bit                 steady       = 1'b0;
  int unsigned        fail_count   = 0;
  int unsigned        result_count = 0;
  int unsigned        dc_count     = 0;
  int unsigned        clip_count   = 0;
  int unsigned        scale_writes = 0;
  int unsigned        cycle_count  = 0;

  spectral_poisson_green_scaler #(
    .GRID_SIZE(GRID)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_index_x   (in_index_x),
    .in_index_y   (in_index_y),
    .in_index_z   (in_index_z),
    .in_coef_real (in_coef_real),
    .in_coef_imag (in_coef_imag),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pot_real (out_pot_real),
    .out_pot_imag (out_pot_imag),
    .out_dc_zeroed(out_dc_zeroed),
    .out_saturated(out_saturated)
  );

  always #5 clk = ~clk;

  // sin^2(pi*mag/GRID) in Q16: Taylor series of sin in Q2.30, then squared.
  function automatic longint unsigned sin_sq_at(input int unsigned mag);
    longint unsigned angle;
    longint unsigned angle_sq;
    longint unsigned term;
    longint unsigned root;
    longint          acc;
    angle    = (PI_Q30 * mag) / GRID;
    angle_sq = (angle * angle) >> 30;
    term     = angle;
    acc      = longint'(angle);
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * angle_sq) >> 30) / (2 * k * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    root = (acc < 0) ? 64'd0 : 64'(acc);
    return (root * root + (64'd1 << 43)) >> 44;
  endfunction

  // Fold an FFT-ordered index to the magnitude of its signed frequency.
  function automatic int unsigned fold_freq(input logic [IDX_W-1:0] idx);
    int unsigned wrapped;
    wrapped = idx % GRID;
    return (wrapped <= HALF_GRID) ? wrapped : GRID - wrapped;
  endfunction

  // One part of -scale * coef / den, rounded half up: returns {clipped, value}.
  function automatic logic [Q_W:0] green_part(input logic [COEF_W-1:0] raw,
                                              input longint unsigned   den,
                                              input logic [SCALE_W-1:0] scale);
    logic [COEF_W-1:0] magnitude;
    logic [Q_W-1:0]    low;
    longint unsigned   quot;
    magnitude = raw[COEF_W-1] ? (~raw + 1'b1) : raw;
    quot      = (64'(magnitude) * 64'(scale) + den / 2) / den;
    low       = quot[Q_W-1:0];
    if (quot == 0) begin
      return '0;
    end
    if (raw[COEF_W-1]) begin
      // A negative source gives a positive potential.
      if (quot > 64'(POS_MAX)) begin
        return {1'b1, POS_MAX};
      end
      return {1'b0, low};
    end
    if (quot > 64'(NEG_MIN)) begin
      return {1'b1, NEG_MIN};
    end
    return {1'b0, ~low + 1'b1};
  endfunction

  // Spectral potential of one mode under the given spacing factor.
  function automatic potential_t green_potential(input mode_t m,
                                                 input logic [SCALE_W-1:0] scale);
    longint unsigned den;
    logic [Q_W:0]    re_part;
    logic [Q_W:0]    im_part;
    potential_t      res;
    den = sin_sq_lut[fold_freq(m.ix)] + sin_sq_lut[fold_freq(m.iy)]
        + sin_sq_lut[fold_freq(m.iz)];
    if (den == 0) begin
      return DC_ZERO;
    end
    re_part       = green_part(m.re, den, scale);
    im_part       = green_part(m.im, den, scale);
    res.pot_real  = re_part[Q_W-1:0];
    res.pot_imag  = im_part[Q_W-1:0];
    res.dc_zeroed = 1'b0;
    res.saturated = re_part[Q_W] | im_part[Q_W];
    return res;
  endfunction

  // Indices lean toward DC, Nyquist and the first harmonics.
  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return IDX_W'(HALF_GRID);
      2: return $urandom_range(0, 1) ? IDX_W'(1) : IDX_W'(GRID - 1);
      default: return IDX_W'($urandom_range(0, GRID - 1));
    endcase
  endfunction

  // Coefficients: mostly moderate magnitudes so that results do not all clip.
  function automatic logic [COEF_W-1:0] pick_coef();
    logic [COEF_W-1:0] raw;
    int unsigned       roll;
    roll = $urandom_range(0, 19);
    if (roll < 8) begin
      raw = $urandom_range(0, 32'h0003_FFFF);
    end else if (roll < 13) begin
      raw = $urandom >> $urandom_range(0, 31);
    end else if (roll < 17) begin
      return $urandom;
    end else begin
      case ($urandom_range(0, 4))
        0: return '0;
        1: return 32'h0000_0001;
        2: return '1;
        3: return 32'h7FFF_FFFF;
        default: return 32'h8000_0000;
      endcase
    end
    if ($urandom_range(0, 1)) begin
      raw = ~raw + 1'b1;
    end
    return raw;
  endfunction

  function automatic mode_t random_mode();
    mode_t m;
    m.ix = pick_index();
    m.iy = pick_index();
    m.iz = pick_index();
    m.re = pick_coef();
    m.im = pick_coef();
    // Some DC modes on purpose, since random indices rarely line up on zero.
    if ($urandom_range(0, 99) < 8) begin
      m.ix = '0;
      m.iy = '0;
      m.iz = '0;
    end
    return m;
  endfunction

  // Present one mode, with random idle cycles first, and wait for its transfer.
  task automatic offer_mode(input mode_t m, input logic pinned, input potential_t want);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_index_x   <= m.ix;
    in_index_y   <= m.iy;
    in_index_z   <= m.iz;
    in_coef_real <= m.re;
    in_coef_imag <= m.im;
    pin_on       <= pinned;
    pin_want     <= want;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_potentials.size() != 0) begin
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  // Change the spacing factor while the pipeline is empty.
  task automatic load_scale(input logic [SCALE_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    green_scale = value;
    scale_writes++;
  endtask

  // Result side stalls at random, except during the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results still due.",
               cycle_count, pending_potentials.size());
      $display("[spectral_poisson_green_scaler] ERROR");
      $finish;
    end
  end

  // Record the expected potential on each input transfer and check each
  // output transfer against the oldest one.
  always @(posedge clk) begin
    potential_t got;
    potential_t want;
    if (in_valid && in_ready) begin
      if (pin_on) begin
        pending_potentials.push_back(pin_want);
      end else begin
        pending_potentials.push_back(green_potential(
            mode_t'{in_index_x, in_index_y, in_index_z, in_coef_real, in_coef_imag},
            green_scale));
      end
    end
    if (out_valid && out_ready) begin
      got = potential_t'{out_pot_real, out_pot_imag, out_dc_zeroed, out_saturated};
      result_count++;
      if (got.dc_zeroed) dc_count++;
      if (got.saturated) clip_count++;
      if (pending_potentials.size() == 0) begin
        $error("unexpected result: pot_real %h pot_imag %h dc_zeroed %b saturated %b",
               got.pot_real, got.pot_imag, got.dc_zeroed, got.saturated);
        fail_count++;
      end else begin
        want = pending_potentials.pop_front();
        if (got.pot_real !== want.pot_real) begin
          $error("pot_real: expected %h, got %h", want.pot_real, got.pot_real);
          fail_count++;
        end
        if (got.pot_imag !== want.pot_imag) begin
          $error("pot_imag: expected %h, got %h", want.pot_imag, got.pot_imag);
          fail_count++;
        end
        if (got.dc_zeroed !== want.dc_zeroed) begin
          $error("dc_zeroed: expected %b, got %b", want.dc_zeroed, got.dc_zeroed);
          fail_count++;
        end
        if (got.saturated !== want.saturated) begin
          $error("saturated: expected %b, got %b", want.saturated, got.saturated);
          fail_count++;
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    logic [SCALE_W-1:0] phase_scale [RAND_PHASES];
    for (int a = 0; a <= HALF_GRID; a++) begin
      sin_sq_lut[a] = sin_sq_at(a);
    end
    phase_scale = '{$urandom_range(32'h0000_8000, 32'h0002_0000), $urandom, SCALE_MAX,
                    $urandom_range(1, 32'h0000_0100), SCALE_RESET};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Probe table; the first rows run on the reset value of the spacing factor.
    foreach (probe_rows[r]) begin
      if (probe_rows[r].scale != green_scale) begin
        load_scale(probe_rows[r].scale);
      end
      offer_mode(probe_rows[r].mode, probe_rows[r].pinned, probe_rows[r].want);
    end

    // Random modes, one spacing factor per phase. The third phase runs with no
    // idling on either side, and the second one drains fully halfway through.
    for (int p = 0; p < RAND_PHASES; p++) begin
      load_scale(phase_scale[p]);
      steady = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == PHASE_ITEMS / 2) begin
          wait_drained();
        end
        offer_mode(random_mode(), 1'b0, ALL_ZERO);
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results (%0d probes, %0d random) over %0d spacing writes.",
             result_count, PROBE_COUNT, RAND_PHASES * PHASE_ITEMS, scale_writes);
    $display("DC modes zeroed: %0d, clipped results: %0d, mismatches: %0d.",
             dc_count, clip_count, fail_count);
    if (fail_count == 0 && pending_potentials.size() == 0) begin
      $display("[spectral_poisson_green_scaler] OK");
    end else begin
      $display("[spectral_poisson_green_scaler] ERROR");
    end
    $finish;
  end

endmodule
